// File: rtl/slt_pkg.sv
// Package for the sorted list table: sizes, command codes, word types,
// controller states and the memory write bundle.
// No dependencies; every other file of the block refers to it by scoped names.
package slt_pkg;

  // Number of entries the table can hold.
  localparam int CAPACITY = 64;

  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 7;
  localparam int ENTRY_W = 7;
  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [ENTRY_W-1:0]       entry_count;
  } rsp_t;

  // Finished result handed from the controller to the output register.
  typedef struct packed {
    logic valid;
    rsp_t word;
  } fin_t;

  // Write port of the entry memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_INS,
    ST_INS_HEAD,
    ST_REM,
    ST_HOLD
  } state_t;

endpackage

// File: rtl/slt_ram.sv
// Entry memory of the sorted list table: one write port, one read port,
// registered read data. Depends on slt_pkg for sizes and the write bundle.
module slt_ram (
  input  logic                          clk,
  input  slt_pkg::ram_wr_t              wr,
  input  logic [slt_pkg::ADDR_W-1:0]    raddr,
  output logic [slt_pkg::DATA_W-1:0]    rdata
);

  logic [slt_pkg::DATA_W-1:0] mem [slt_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/slt_ctrl.sv
// Command sequencer of the sorted list table: scans the entry memory one
// address per cycle to insert or remove, and reads one address for a read. Depends on slt_pkg.
module slt_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  slt_pkg::req_t                 req,
  output logic                          busy,
  input  logic                          out_free,
  output slt_pkg::fin_t                 fin,
  output slt_pkg::ram_wr_t              wr,
  output logic [slt_pkg::ADDR_W-1:0]    raddr,
  input  logic [slt_pkg::DATA_W-1:0]    rdata
);

  slt_pkg::state_t state, state_next;

  logic [slt_pkg::CNT_W-1:0]  count, count_next;
  logic [slt_pkg::ADDR_W-1:0] scan, scan_next;
  logic                       issue_on, issue_on_next;
  logic                       pend, pend_next;
  logic [slt_pkg::ADDR_W-1:0] paddr, paddr_next;
  logic                       found, found_next;
  logic signed [slt_pkg::DATA_W-1:0] v, v_next;
  slt_pkg::rsp_t              held;

  logic [slt_pkg::ADDR_W-1:0] count_m1;
  logic                       is_full, is_empty, idx_ok;
  logic                       ins_shift, rem_hit, rem_last;
  logic                       fin_ok;
  logic [slt_pkg::DATA_W-1:0] fin_val;

  assign count_m1  = slt_pkg::ADDR_W'(count - 1'b1);
  assign is_full   = (count == slt_pkg::CNT_W'(slt_pkg::CAPACITY));
  assign is_empty  = (count == '0);
  assign idx_ok    = (req.index != '0) &&
                     (slt_pkg::CMP_W'(req.index) <= slt_pkg::CMP_W'(count));
  assign ins_shift = (v < $signed(rdata));
  assign rem_hit   = (rdata == v);
  assign rem_last  = (paddr == count_m1);
  assign busy      = (state != slt_pkg::ST_IDLE);

  // Datapath and outputs.
  always_comb begin
    count_next    = count;
    scan_next     = scan;
    issue_on_next = 1'b0;
    pend_next     = 1'b0;
    paddr_next    = scan;
    found_next    = found;
    v_next        = v;
    raddr         = scan;
    wr            = '0;
    fin.valid     = 1'b0;
    fin_ok        = 1'b0;
    fin_val       = '0;
    unique case (state)
      slt_pkg::ST_IDLE: begin
        v_next = req.value;
        if (req_valid) begin
          unique case (req.cmd)
            slt_pkg::CMD_INSERT: begin
              if (is_full) begin
                fin.valid = 1'b1;
              end else if (is_empty) begin
                wr.we      = 1'b1;
                wr.addr    = '0;
                wr.data    = req.value;
                fin.valid  = 1'b1;
                fin_ok     = 1'b1;
                count_next = count + 1'b1;
              end else begin
                scan_next     = count_m1;
                issue_on_next = 1'b1;
              end
            end
            slt_pkg::CMD_REMOVE: begin
              if (is_empty) begin
                fin.valid = 1'b1;
              end else begin
                scan_next     = '0;
                issue_on_next = 1'b1;
                found_next    = 1'b0;
              end
            end
            slt_pkg::CMD_READ: begin
              if (idx_ok) begin
                raddr = slt_pkg::ADDR_W'(req.index) - 1'b1;
              end else begin
                fin.valid = 1'b1;
              end
            end
            slt_pkg::CMD_CLEAR: begin
              count_next = '0;
              fin.valid  = 1'b1;
              fin_ok     = 1'b1;
            end
          endcase
        end
      end
      slt_pkg::ST_READ: begin
        fin.valid = 1'b1;
        fin_ok    = 1'b1;
        fin_val   = rdata;
      end
      slt_pkg::ST_INS: begin
        pend_next = issue_on;
        if (issue_on) begin
          scan_next     = scan - 1'b1;
          issue_on_next = (scan != '0);
        end
        if (pend) begin
          wr.we   = 1'b1;
          wr.addr = paddr + 1'b1;
          if (ins_shift) begin
            wr.data = rdata;
          end else begin
            wr.data    = v;
            fin.valid  = 1'b1;
            fin_ok     = 1'b1;
            count_next = count + 1'b1;
          end
        end
      end
      slt_pkg::ST_INS_HEAD: begin
        wr.we      = 1'b1;
        wr.addr    = '0;
        wr.data    = v;
        fin.valid  = 1'b1;
        fin_ok     = 1'b1;
        count_next = count + 1'b1;
      end
      slt_pkg::ST_REM: begin
        pend_next = issue_on;
        if (issue_on) begin
          if (scan == count_m1) begin
            issue_on_next = 1'b0;
          end else begin
            scan_next     = scan + 1'b1;
            issue_on_next = 1'b1;
          end
        end
        if (pend) begin
          // Once the match is seen, every later entry moves down one place.
          if (found) begin
            wr.we   = 1'b1;
            wr.addr = paddr - 1'b1;
            wr.data = rdata;
          end else if (rem_hit) begin
            found_next = 1'b1;
          end
          if (rem_last) begin
            fin.valid = 1'b1;
            fin_ok    = found || rem_hit;
            if (found || rem_hit) begin
              count_next = count - 1'b1;
            end
          end
        end
      end
      slt_pkg::ST_HOLD: begin
        fin.valid = 1'b1;
      end
      default: begin
      end
    endcase
    if (state == slt_pkg::ST_HOLD) begin
      fin.word = held;
    end else begin
      fin.word.ok          = fin_ok;
      fin.word.read_value  = fin_val;
      fin.word.entry_count = slt_pkg::ENTRY_W'(count_next);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    if (fin.valid) begin
      state_next = out_free ? slt_pkg::ST_IDLE : slt_pkg::ST_HOLD;
    end else begin
      unique case (state)
        slt_pkg::ST_IDLE: begin
          if (req_valid) begin
            unique case (req.cmd)
              slt_pkg::CMD_INSERT: state_next = slt_pkg::ST_INS;
              slt_pkg::CMD_REMOVE: state_next = slt_pkg::ST_REM;
              slt_pkg::CMD_READ:   state_next = slt_pkg::ST_READ;
              slt_pkg::CMD_CLEAR:  state_next = slt_pkg::ST_IDLE;
            endcase
          end
        end
        slt_pkg::ST_INS: begin
          if (pend && ins_shift && (paddr == '0)) begin
            state_next = slt_pkg::ST_INS_HEAD;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= slt_pkg::ST_IDLE;
      count    <= '0;
      issue_on <= 1'b0;
      pend     <= 1'b0;
      found    <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      issue_on <= issue_on_next;
      pend     <= pend_next;
      found    <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    scan  <= scan_next;
    paddr <= paddr_next;
    v     <= v_next;
    if (fin.valid && (state != slt_pkg::ST_HOLD)) begin
      held <= fin.word;
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= slt_pkg::CNT_W'(slt_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  // The memory is only written while a command is in progress or accepted.
  a_write_ctx: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> (state != slt_pkg::ST_IDLE) || req_valid)
    else $error("memory write with no command");

  // A remove writes only after the match has been seen.
  a_rem_found: assert property (@(posedge clk) disable iff (rst)
    (state == slt_pkg::ST_REM && wr.we) |-> found)
    else $error("remove shifted before the match");

  // During a scan the write never hits the address being read.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    ((state == slt_pkg::ST_INS || state == slt_pkg::ST_REM) && wr.we && issue_on)
      |-> (wr.addr != raddr))
    else $error("read and write collide during scan");

endmodule

// File: rtl/sorted_list_table.sv
// Top level of the sorted list table: output register, command sequencer
// and entry memory. Depends on slt_pkg, slt_ram and slt_ctrl.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   slt_pkg::req_t (cmd, value, index)
//   rsp      out        rsp_valid/rsp_stall   slt_pkg::rsp_t (ok, read_value, entry_count)
//
// Clear, insert into an empty table and commands failing on their bounds finish in the
// accepting cycle; read finishes in ST_READ on the registered read data; remove and insert
// scan through the entry memory at one address per cycle.
// Reset empties the table at once by zeroing the count; the memory is not cleared.
// The next word is taken while a result waits in the output register; a result
// that finds the register still stalled is held and blocks new words until taken.
module sorted_list_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  slt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output slt_pkg::rsp_t rsp
);

  logic                       busy;
  logic                       out_free;
  slt_pkg::fin_t              fin;
  slt_pkg::ram_wr_t           wr;
  logic [slt_pkg::ADDR_W-1:0] raddr;
  logic [slt_pkg::DATA_W-1:0] rdata;

  // The output register can take a result when it is empty or being drained.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = busy;

  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .busy      (busy),
    .out_free  (out_free),
    .fin       (fin),
    .wr        (wr),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  slt_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin.valid && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid && out_free) begin
      rsp <= fin.word;
    end
  end

  // A result is never dropped: a finished result is loaded or held.
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (fin.valid && !out_free) |=> fin.valid)
    else $error("finished result lost");

  // A result that is not ok carries a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ok) |-> (rsp.read_value == '0))
    else $error("failed command returned a value");

  // Words are only accepted while no result is held back.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> !(fin.valid && !out_free && busy))
    else $error("word accepted while result held");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for sorted_list_table: drives command words, predicts
// every result from its own ordered table copy and checks each response word.
// Depends on slt_pkg and the sorted_list_table RTL.
`timescale 1ns / 1ps

module testbench;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid;
  logic          req_stall;
  slt_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  slt_pkg::rsp_t rsp;

  sorted_list_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own copy of the table: values kept in ascending signed order, and how
  // many of them are valid.
  logic signed [slt_pkg::DATA_W-1:0] held_vals [slt_pkg::CAPACITY];
  int                                held_count;

  // Response words we expect, oldest first.
  slt_pkg::rsp_t pending_results [$];
  int            fail_count;

  // Idling controls. The quiet flags give stretches with no idling at all;
  // hold_req asks the receiver for one long hold-off.
  bit tx_quiet;
  bit rx_quiet;
  bit hold_req;
  localparam int LONG_HOLD = 400;

  // Mostly no gap, sometimes a short one, once in a while a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Any index the field can carry.
  function automatic logic [slt_pkg::IDX_W-1:0] rand_idx();
    return slt_pkg::IDX_W'($urandom);
  endfunction

  // Applies one command to our table copy and returns the response word the
  // block should produce for it.
  function automatic slt_pkg::rsp_t apply_command(slt_pkg::req_t w);
    slt_pkg::rsp_t res;
    int            pos;
    res = '0;
    case (w.cmd)
      slt_pkg::CMD_INSERT: begin
        if (held_count < slt_pkg::CAPACITY) begin
          // New value lands after every entry that is not greater than it,
          // so duplicates keep arrival order.
          pos = 0;
          while (pos < held_count && !(w.value < held_vals[pos])) pos++;
          for (int i = held_count; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = w.value;
          held_count++;
          res.ok = 1'b1;
        end
      end
      slt_pkg::CMD_REMOVE: begin
        // Only the first matching entry goes.
        pos = 0;
        while (pos < held_count && held_vals[pos] != w.value) pos++;
        if (pos < held_count) begin
          for (int i = pos; i + 1 < held_count; i++) held_vals[i] = held_vals[i+1];
          held_count--;
          res.ok = 1'b1;
        end
      end
      slt_pkg::CMD_READ: begin
        if (w.index >= 1 && w.index <= held_count) begin
          res.ok         = 1'b1;
          res.read_value = held_vals[w.index - 1];
        end
      end
      default: begin
        held_count = 0;
        res.ok     = 1'b1;
      end
    endcase
    res.entry_count = held_count[slt_pkg::ENTRY_W-1:0];
    return res;
  endfunction

  function automatic slt_pkg::req_t make_word(logic [slt_pkg::CMD_W-1:0] c,
                                              logic signed [slt_pkg::DATA_W-1:0] v,
                                              logic [slt_pkg::IDX_W-1:0] i);
    slt_pkg::req_t w;
    w.cmd   = c;
    w.value = v;
    w.index = i;
    return w;
  endfunction

  // Offers one word from a falling edge, waits for the edge that takes it,
  // records the expected response, then idles for a random gap. Returns at a
  // falling edge with valid still high when there is no gap, so that the next
  // word follows back to back.
  task automatic send_word(slt_pkg::req_t w);
    int gap;
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(apply_command(w));
    @(negedge clk);
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      req       <= make_word(slt_pkg::CMD_W'($urandom_range(0, 3)), $urandom, rand_idx());
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops offering words and waits until every expected response has come.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Value source: a narrow pool makes duplicates and hits on remove likely,
  // extremes keep the sign boundary busy, the rest spans the full range.
  function automatic logic signed [slt_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3, 4: return $signed($urandom_range(0, 40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  // One random command. insert_pct steers the fill level of the table, so a
  // run can climb to full and fall back to empty.
  function automatic slt_pkg::req_t random_word(int insert_pct);
    int                                r;
    logic signed [slt_pkg::DATA_W-1:0] v;
    logic [slt_pkg::IDX_W-1:0]         idx;
    r   = $urandom_range(0, 99);
    idx = rand_idx();
    if (r < insert_pct) return make_word(slt_pkg::CMD_INSERT, pick_value(), idx);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // Removes mostly name a value that is really held.
      if (held_count > 0 && $urandom_range(0, 99) < 70)
        v = held_vals[$urandom_range(0, held_count - 1)];
      else
        v = pick_value();
      return make_word(slt_pkg::CMD_REMOVE, v, idx);
    end
    if (r < 96) begin
      case ($urandom_range(0, 9))
        0:       idx = '0;
        1:       idx = rand_idx();
        default: idx = slt_pkg::IDX_W'($urandom_range(1, held_count + 1));
      endcase
      return make_word(slt_pkg::CMD_READ, $urandom, idx);
    end
    return make_word(slt_pkg::CMD_CLEAR, $urandom, idx);
  endfunction

  // Receiver side: random runs of ready and stall, quiet stretches with no
  // stall, and one long hold-off on request, counted here in cycles.
  initial begin : rsp_stall_driver
    int stall_left;
    int go_left;
    stall_left = 0;
    go_left    = 0;
    rsp_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
        go_left    = 0;
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else if (go_left > 0 || rx_quiet) begin
        rsp_stall <= 1'b0;
        if (go_left > 0) go_left--;
      end else begin
        rsp_stall <= 1'b0;
        go_left    = $urandom_range(1, 12);
        stall_left = idle_len();
      end
    end
  end

  // Every response word taken is checked field by field against the oldest
  // expectation.
  always @(posedge clk) begin
    slt_pkg::rsp_t exp_word;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: response with nothing expected: ok %0b, read_value %0d, count %0d",
                 $time, rsp.ok, rsp.read_value, rsp.entry_count);
        fail_count++;
      end else begin
        exp_word = pending_results.pop_front();
        if (rsp.ok !== exp_word.ok) begin
          $display("%0t: ok mismatch, expected %0b, actual %0b",
                   $time, exp_word.ok, rsp.ok);
          fail_count++;
        end
        if (rsp.read_value !== exp_word.read_value) begin
          $display("%0t: read_value mismatch, expected %0d, actual %0d",
                   $time, exp_word.read_value, rsp.read_value);
          fail_count++;
        end
        if (rsp.entry_count !== exp_word.entry_count) begin
          $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                   $time, exp_word.entry_count, rsp.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Hand-picked words: empty-table failures, signed extremes, duplicates,
  // read bounds, a missing remove and clear on both a filled and an empty table.
  task automatic test_directed();
    send_word(make_word(slt_pkg::CMD_REMOVE, 32'sd7, rand_idx()));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd1));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd0));
    send_word(make_word(slt_pkg::CMD_CLEAR, $urandom, rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, 32'sd0, 7'd127));
    send_word(make_word(slt_pkg::CMD_INSERT, 32'sh7FFF_FFFF, rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, 32'sh8000_0000, rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, -32'sd1, rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, 32'sd1, rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, 32'sd5, rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, 32'sd5, rand_idx()));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd1));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd4));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd7));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd8));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd127));
    send_word(make_word(slt_pkg::CMD_REMOVE, 32'sd5, rand_idx()));
    send_word(make_word(slt_pkg::CMD_REMOVE, 32'sd99, rand_idx()));
    send_word(make_word(slt_pkg::CMD_REMOVE, 32'sh8000_0000, rand_idx()));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd1));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd6));
    send_word(make_word(slt_pkg::CMD_CLEAR, $urandom, rand_idx()));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd1));
  endtask

  // Fills the table to capacity, tries to overfill it, reads at the ends and
  // frees one slot to refill it.
  task automatic test_full_table();
    for (int i = 0; i < slt_pkg::CAPACITY; i++)
      send_word(make_word(slt_pkg::CMD_INSERT, pick_value(), rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, $urandom, rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, 32'sh7FFF_FFFF, rand_idx()));
    send_word(make_word(slt_pkg::CMD_READ, $urandom,
                        slt_pkg::IDX_W'(slt_pkg::CAPACITY)));
    send_word(make_word(slt_pkg::CMD_READ, $urandom,
                        slt_pkg::IDX_W'(slt_pkg::CAPACITY + 1)));
    send_word(make_word(slt_pkg::CMD_READ, $urandom, 7'd1));
    send_word(make_word(slt_pkg::CMD_REMOVE,
                        held_vals[$urandom_range(0, slt_pkg::CAPACITY - 1)], rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, 32'sh8000_0000, rand_idx()));
    send_word(make_word(slt_pkg::CMD_INSERT, 32'sd3, rand_idx()));
    send_word(make_word(slt_pkg::CMD_CLEAR, $urandom, rand_idx()));
  endtask

  // Random mix in phases that push the table up toward full and back down,
  // first with no idling on either side, then with random idling.
  task automatic test_random_mix();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (80) send_word(random_word(55));
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    for (int phase = 0; phase < 6; phase++)
      repeat (55) send_word(random_word((phase % 2 == 0) ? 65 : 20));
  endtask

  // The receiver holds off for a long stretch while words keep coming back to
  // back, so the block fills up and must stall its input.
  task automatic test_backpressure();
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (12) send_word(random_word(50));
    tx_quiet = 1'b0;
  endtask

  // The sender pauses until everything has come back, then resumes.
  task automatic test_drain_pause();
    wait_drained();
    repeat (15) send_word(random_word(40));
  endtask

  initial begin
    req_valid  = 1'b0;
    req        = '0;
    tx_quiet   = 1'b0;
    rx_quiet   = 1'b0;
    hold_req   = 1'b0;
    fail_count = 0;
    held_count = 0;
    for (int i = 0; i < slt_pkg::CAPACITY; i++) held_vals[i] = '0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_table();
    test_random_mix();
    test_backpressure();
    test_drain_pause();

    // Let the block settle for longer than the slowest insert before judging.
    wait_drained();
    repeat (slt_pkg::CAPACITY * 3) @(negedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
